// ===== rtl/mdsl_pkg.sv =====
// shared types and constants for the motor duty slew limiter
package mdsl_pkg;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_POS  = 2'd1,
    DIR_NEG  = 2'd2
  } dir_e;

  // item kinds carried in tuser
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_STOP = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_ACCEL_RATE   = 2'd0;
  localparam logic [1:0] REG_DECEL_RATE   = 2'd1;
  localparam logic [1:0] REG_REVERSE_RATE = 2'd2;
  localparam logic [1:0] REG_ZERO_HOLD_MS = 2'd3;

  localparam int unsigned RATE_W = 24;
  localparam int unsigned DT_W   = 16;
  localparam int unsigned HOLD_W = 26;
  localparam int unsigned REST_W = 30;
  localparam int unsigned MS_W   = 16;
  localparam int unsigned PROD_W = RATE_W + DT_W;
  localparam int unsigned STEP_W = PROD_W - 16;

  localparam logic [RATE_W-1:0] RATE_RESET = 24'd2147;
  localparam logic [REST_W-1:0] REST_CAP   = 30'd1000000000;
  localparam logic [HOLD_W-1:0] US_PER_MS  = 26'd1000;

endpackage

// ===== rtl/motor_duty_slew_limiter.sv =====
// motor duty slew limiter with reversal dead time, top level
// the result of an item is registered from the input register into the output register
// throughput: one item per cycle unless the output stalls; the rate multiply and the limit
// compares sit in one stage between input and output registers; duty state updates alongside
// reset: duty, direction and hold clear, rest time goes to its 1e9 us cap, rates to 2147,
// zero hold to 0; both stages empty
module motor_duty_slew_limiter #(
  parameter int unsigned DutyBits = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // tdata: target, dt_us (lowest bits first), zero padded
  input  logic [((DutyBits+16+7)/8)*8-1:0] s_axis_tdata,
  // tuser: op
  input  logic                         s_axis_tuser,
  // result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // tdata: duty, hold_left_us (lowest bits first), zero padded
  output logic [((DutyBits+26+7)/8)*8-1:0] m_axis_tdata,
  // configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [1:0]                   cfg_index_i,
  input  logic [23:0]                  cfg_data_i
);

  localparam int unsigned OutW  = ((DutyBits + 26 + 7) / 8) * 8;
  localparam int unsigned StepW = mdsl_pkg::STEP_W;
  localparam int unsigned CmpW  = (DutyBits + 1 > StepW + 1) ? DutyBits + 1 : StepW + 1;
  localparam int unsigned PadW  = OutW - DutyBits - mdsl_pkg::HOLD_W;

  localparam logic signed [DutyBits-1:0] DutyMin   = {1'b1, {(DutyBits-1){1'b0}}};
  localparam logic signed [DutyBits-1:0] DutyFs    = {1'b0, {(DutyBits-1){1'b1}}};
  localparam logic signed [DutyBits-1:0] DutyNegFs = -DutyFs;

  // configuration
  logic [mdsl_pkg::RATE_W-1:0] accel_q, decel_q, reverse_q;
  logic [mdsl_pkg::HOLD_W-1:0] hold_us_q;

  // input register
  logic                         in_valid_q;
  logic                         in_op_q;
  logic signed [DutyBits-1:0]   in_target_q;
  logic [mdsl_pkg::DT_W-1:0]    in_dt_q;

  // state
  logic signed [DutyBits-1:0]   duty_q, duty_d;
  logic [mdsl_pkg::REST_W-1:0]  rest_q, rest_d;
  mdsl_pkg::dir_e               dir_q, dir_d;
  logic [mdsl_pkg::HOLD_W-1:0]  hold_q, hold_d;

  // output register
  logic                         out_valid_q;
  logic signed [DutyBits-1:0]   out_duty_q;
  logic [mdsl_pkg::HOLD_W-1:0]  out_hold_q;

  logic advance;
  logic take_in;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign take_in       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{PadW{1'b0}}, out_hold_q, out_duty_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q   <= mdsl_pkg::RATE_RESET;
      decel_q   <= mdsl_pkg::RATE_RESET;
      reverse_q <= mdsl_pkg::RATE_RESET;
      hold_us_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        mdsl_pkg::REG_ACCEL_RATE:   accel_q   <= cfg_data_i;
        mdsl_pkg::REG_DECEL_RATE:   decel_q   <= cfg_data_i;
        mdsl_pkg::REG_REVERSE_RATE: reverse_q <= cfg_data_i;
        mdsl_pkg::REG_ZERO_HOLD_MS: begin
          // kept in microseconds so the tick path needs no second multiply
          hold_us_q <= mdsl_pkg::HOLD_W'(cfg_data_i[mdsl_pkg::MS_W-1:0]) * mdsl_pkg::US_PER_MS;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (take_in) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_op_q     <= s_axis_tuser;
      in_target_q <= s_axis_tdata[DutyBits-1:0];
      in_dt_q     <= s_axis_tdata[DutyBits +: mdsl_pkg::DT_W];
    end
  end

  // datapath
  logic                         duty_zero, duty_pos, duty_neg;
  logic signed [DutyBits-1:0]   tgt_c;
  logic                         tgt_pos, tgt_neg;
  mdsl_pkg::dir_e               dir_cur;
  logic [mdsl_pkg::REST_W:0]    rest_sum;
  logic [mdsl_pkg::REST_W-1:0]  rest_cur;
  logic                         holding;
  logic                         reversal;
  logic signed [CmpW-1:0]       duty_ext, tgt_ext, diff, adiff, mag_duty, mag_tgt;
  logic                         accel;
  logic [mdsl_pkg::RATE_W-1:0]  rate_sel;
  logic [mdsl_pkg::PROD_W-1:0]  prod;
  logic signed [CmpW-1:0]       step_ext;
  logic                         rev_reach;
  logic signed [CmpW-1:0]       rev_duty, mv_duty;

  always_comb begin
    duty_zero = (duty_q == '0);
    duty_neg  = duty_q[DutyBits-1];
    duty_pos  = !duty_zero && !duty_neg;

    tgt_c   = (in_target_q == DutyMin) ? DutyNegFs : in_target_q;
    tgt_neg = tgt_c[DutyBits-1];
    tgt_pos = (tgt_c != '0) && !tgt_neg;

    if (duty_pos) begin
      dir_cur = mdsl_pkg::DIR_POS;
    end else if (duty_neg) begin
      dir_cur = mdsl_pkg::DIR_NEG;
    end else begin
      dir_cur = dir_q;
    end

    // time at zero, saturating at the cap
    rest_sum = {1'b0, rest_q} + (mdsl_pkg::REST_W+1)'(in_dt_q);
    if (duty_zero && (rest_q < mdsl_pkg::REST_CAP)) begin
      rest_cur = (rest_sum > {1'b0, mdsl_pkg::REST_CAP}) ? mdsl_pkg::REST_CAP
                                                         : rest_sum[mdsl_pkg::REST_W-1:0];
    end else begin
      rest_cur = rest_q;
    end

    holding = duty_zero &&
              (((dir_cur == mdsl_pkg::DIR_POS) && tgt_neg) ||
               ((dir_cur == mdsl_pkg::DIR_NEG) && tgt_pos)) &&
              (rest_cur < mdsl_pkg::REST_W'(hold_us_q));

    reversal = (duty_pos && tgt_neg) || (duty_neg && tgt_pos);

    duty_ext = CmpW'(duty_q);
    tgt_ext  = CmpW'(tgt_c);
    diff     = tgt_ext - duty_ext;
    adiff    = diff[CmpW-1] ? -diff : diff;
    mag_duty = duty_neg ? -duty_ext : duty_ext;
    mag_tgt  = tgt_neg ? -tgt_ext : tgt_ext;
    accel    = mag_tgt > mag_duty;

    if (reversal) begin
      rate_sel = reverse_q;
    end else if (accel) begin
      rate_sel = accel_q;
    end else begin
      rate_sel = decel_q;
    end

    prod     = mdsl_pkg::PROD_W'(rate_sel) * mdsl_pkg::PROD_W'(in_dt_q);
    step_ext = $signed(CmpW'(prod[mdsl_pkg::PROD_W-1:16]));

    rev_reach = (reverse_q == '0) || (mag_duty <= step_ext);
    rev_duty  = duty_pos ? duty_ext - step_ext : duty_ext + step_ext;

    if (adiff <= step_ext) begin
      mv_duty = tgt_ext;
    end else if (!diff[CmpW-1]) begin
      mv_duty = duty_ext + step_ext;
    end else begin
      mv_duty = duty_ext - step_ext;
    end
  end

  always_comb begin
    duty_d = duty_q;
    rest_d = rest_q;
    dir_d  = dir_q;
    hold_d = hold_q;
    if (in_op_q == mdsl_pkg::OP_STOP) begin
      if (!duty_zero) begin
        rest_d = '0;
      end
      duty_d = '0;
      hold_d = '0;
    end else if (in_dt_q != '0) begin
      dir_d  = dir_cur;
      rest_d = rest_cur;
      hold_d = '0;
      if (holding) begin
        hold_d = hold_us_q - rest_cur[mdsl_pkg::HOLD_W-1:0];
      end else if (reversal) begin
        if (rev_reach) begin
          duty_d = '0;
          rest_d = '0;
          hold_d = hold_us_q;
        end else begin
          duty_d = rev_duty[DutyBits-1:0];
        end
      end else if (adiff != '0) begin
        duty_d = mv_duty[DutyBits-1:0];
        if (!mv_duty[CmpW-1] && (mv_duty != '0)) begin
          dir_d = mdsl_pkg::DIR_POS;
        end else if (mv_duty[CmpW-1]) begin
          dir_d = mdsl_pkg::DIR_NEG;
        end else if (!duty_zero) begin
          rest_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q <= '0;
      rest_q <= mdsl_pkg::REST_CAP;
      dir_q  <= mdsl_pkg::DIR_NONE;
      hold_q <= '0;
    end else if (advance) begin
      duty_q <= duty_d;
      rest_q <= rest_d;
      dir_q  <= dir_d;
      hold_q <= hold_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_duty_q <= duty_d;
      out_hold_q <= hold_d;
    end
  end

`ifndef SYNTHESIS
  // an emergency stop always leaves the duty and the hold at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (in_op_q == mdsl_pkg::OP_STOP) |=> (duty_q == '0) && (hold_q == '0))
    else $error("duty not cleared after stop");

  // a pending reversal hold only ever shows with the duty at rest
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (out_hold_q != '0) |-> (out_duty_q == '0))
    else $error("hold reported while driving");

  // rest time never passes its cap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rest_q <= mdsl_pkg::REST_CAP)
    else $error("rest time above cap");

  // the duty never takes the most negative code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    duty_q != DutyMin)
    else $error("duty out of range");

  // reaching zero from a positive duty restarts the rest time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && duty_pos && (duty_d == '0) |=> (rest_q == '0))
    else $error("rest time not restarted at zero");
`endif

endmodule

// ===== bench/tb_top.sv =====
// self-checking testbench for the motor duty slew limiter: table, long rest and random phases
module tb_top;

  localparam int DUTY_W = 16;
  localparam int SD_W = ((DUTY_W + 16 + 7) / 8) * 8;
  localparam int MD_W = ((DUTY_W + 26 + 7) / 8) * 8;
  localparam longint FULL_SCALE = 32767;
  localparam longint REST_CAP_US = 1000000000;
  localparam int CYCLE_LIMIT = 600000;
  localparam int LONG_REST_TICKS = 999;
  localparam int PHASE_ITEMS = 65;
  localparam int HOLD_OFF_CYCLES = 150;

  typedef struct packed {
    logic signed [15:0] duty;
    logic [25:0]        hold_left;
  } slew_res_t;

  typedef struct packed {
    logic               op;
    logic signed [15:0] target;
    logic [15:0]        dt;
    logic               known;
    logic signed [15:0] duty;
    logic [25:0]        hold_left;
  } stim_row_t;

  // table run with accel at full range, decel 40000, reverse 65536, hold 1 ms
  localparam stim_row_t STEER_ROWS [23] = '{
    '{mdsl_pkg::OP_TICK, 16'sd0,      16'd0,     1'b1, 16'sd0,      26'd0},
    '{mdsl_pkg::OP_STOP, 16'sh8000,   16'd65535, 1'b1, 16'sd0,      26'd0},
    '{mdsl_pkg::OP_TICK, 16'sh8000,   16'd65535, 1'b1, -16'sd32767, 26'd0},
    '{mdsl_pkg::OP_TICK, -16'sd32767, 16'd5,     1'b1, -16'sd32767, 26'd0},
    '{mdsl_pkg::OP_TICK, -16'sd32767, 16'd0,     1'b1, -16'sd32767, 26'd0},
    '{mdsl_pkg::OP_TICK, -16'sd100,   16'd3,     1'b0, 16'sd0,      26'd0},
    '{mdsl_pkg::OP_TICK, 16'sd32767,  16'd65535, 1'b1, 16'sd0,      26'd1000},
    '{mdsl_pkg::OP_TICK, 16'sd32767,  16'd400,   1'b1, 16'sd0,      26'd600},
    '{mdsl_pkg::OP_TICK, 16'sd32767,  16'd0,     1'b1, 16'sd0,      26'd600},
    '{mdsl_pkg::OP_TICK, 16'sd32767,  16'd600,   1'b1, 16'sd32767,  26'd0},
    '{mdsl_pkg::OP_TICK, 16'sd32767,  16'd65535, 1'b1, 16'sd32767,  26'd0},
    '{mdsl_pkg::OP_STOP, 16'sd1234,   16'd77,    1'b1, 16'sd0,      26'd0},
    '{mdsl_pkg::OP_TICK, -16'sd5,     16'd1,     1'b1, 16'sd0,      26'd999},
    '{mdsl_pkg::OP_TICK, 16'sd5,      16'd1,     1'b0, 16'sd0,      26'd0},
    '{mdsl_pkg::OP_TICK, 16'sd0,      16'd1,     1'b0, 16'sd0,      26'd0},
    '{mdsl_pkg::OP_TICK, 16'sd0,      16'd2,     1'b0, 16'sd0,      26'd0},
    '{mdsl_pkg::OP_TICK, -16'sd32767, 16'd1,     1'b0, 16'sd0,      26'd0},
    '{mdsl_pkg::OP_TICK, -16'sd32767, 16'd3,     1'b0, 16'sd0,      26'd0},
    '{mdsl_pkg::OP_TICK, -16'sd1,     16'd65535, 1'b0, 16'sd0,      26'd0},
    '{mdsl_pkg::OP_TICK, 16'sd0,      16'd7,     1'b0, 16'sd0,      26'd0},
    '{mdsl_pkg::OP_TICK, 16'sd1,      16'd50,    1'b0, 16'sd0,      26'd0},
    '{mdsl_pkg::OP_STOP, -16'sd1,     16'd65535, 1'b0, 16'sd0,      26'd0},
    '{mdsl_pkg::OP_TICK, 16'sd32767,  16'd65535, 1'b0, 16'sd0,      26'd0}
  };

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [SD_W-1:0]  s_axis_tdata = '0;
  logic             s_axis_tuser = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [MD_W-1:0]  m_axis_tdata;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [1:0]       cfg_index_i = '0;
  logic [23:0]      cfg_data_i = '0;

  // shadow copy of the registers and the slew state
  logic [23:0]        accel_r = mdsl_pkg::RATE_RESET;
  logic [23:0]        decel_r = mdsl_pkg::RATE_RESET;
  logic [23:0]        reverse_r = mdsl_pkg::RATE_RESET;
  logic [15:0]        hold_ms_r = '0;
  logic signed [15:0] duty_st = '0;
  longint             rest_st = REST_CAP_US;
  mdsl_pkg::dir_e     dir_st = mdsl_pkg::DIR_NONE;
  logic [25:0]        hold_st = '0;

  slew_res_t duty_expq [$];
  int        errors = 0;
  int        cycles = 0;
  bit        quiet = 1'b0;
  int        stall_reqs = 0;

  motor_duty_slew_limiter DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic slew_res_t slew_predict(input logic op, input logic signed [15:0] tgt_in,
                                             input logic [15:0] dt);
    longint    tgt, cur, stp, diff, nxt, hold_us;
    bit        accel;
    slew_res_t res;
    hold_us = longint'(hold_ms_r) * 1000;
    cur = duty_st;
    tgt = tgt_in;
    if (tgt < -FULL_SCALE) tgt = -FULL_SCALE;
    if (op == mdsl_pkg::OP_STOP) begin
      if (cur != 0) rest_st = 0;
      duty_st = '0;
      hold_st = '0;
    end else if (dt != 0) begin
      if (cur > 0) begin
        dir_st = mdsl_pkg::DIR_POS;
      end else if (cur < 0) begin
        dir_st = mdsl_pkg::DIR_NEG;
      end else if (rest_st < REST_CAP_US) begin
        rest_st = rest_st + longint'(dt);
        if (rest_st > REST_CAP_US) rest_st = REST_CAP_US;
      end
      hold_st = '0;
      if (cur == 0 &&
          ((dir_st == mdsl_pkg::DIR_POS && tgt < 0) ||
           (dir_st == mdsl_pkg::DIR_NEG && tgt > 0)) &&
          rest_st < hold_us) begin
        hold_st = 26'(hold_us - rest_st);
      end else if ((cur > 0 && tgt < 0) || (cur < 0 && tgt > 0)) begin
        // wind down toward zero, never through it
        stp = (longint'(reverse_r) * longint'(dt)) >>> 16;
        if (reverse_r == 0 || magnitude(cur) <= stp) begin
          duty_st = '0;
          rest_st = 0;
          hold_st = 26'(hold_us);
        end else begin
          duty_st = 16'((cur > 0) ? cur - stp : cur + stp);
        end
      end else if (tgt != cur) begin
        accel = magnitude(tgt) > magnitude(cur);
        stp = (longint'(accel ? accel_r : decel_r) * longint'(dt)) >>> 16;
        diff = tgt - cur;
        if (magnitude(diff) <= stp) nxt = tgt;
        else nxt = (diff > 0) ? cur + stp : cur - stp;
        duty_st = 16'(nxt);
        if (nxt > 0) dir_st = mdsl_pkg::DIR_POS;
        else if (nxt < 0) dir_st = mdsl_pkg::DIR_NEG;
        else if (cur != 0) rest_st = 0;
      end
    end
    res.duty = duty_st;
    res.hold_left = hold_st;
    return res;
  endfunction

  function automatic logic [15:0] pick_dt();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 16'd0;
    if (r < 45) return 16'($urandom_range(1, 64));
    if (r < 75) return 16'($urandom);
    if (r < 85) return 16'hFFFF;
    return 16'($urandom_range(1, 2000));
  endfunction

  task automatic push_item(input logic op, input logic signed [15:0] tgt, input logic [15:0] dt,
                           input bit known = 1'b0, input slew_res_t typed = '0);
    slew_res_t res;
    while (!quiet && $urandom_range(99) < 18) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= SD_W'({dt, tgt});
    do @(posedge clk_i); while (!s_axis_tready);
    res = slew_predict(op, tgt, dt);
    duty_expq.push_back(known ? typed : res);
  endtask

  task automatic await_drain();
    s_axis_tvalid <= 1'b0;
    while (duty_expq.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [23:0] acc, input logic [23:0] dec,
                            input logic [23:0] rev, input logic [15:0] hms);
    logic [23:0] vals [4];
    logic [1:0]  idx [4];
    vals = '{acc, dec, rev, {8'($urandom), hms}};
    idx = '{mdsl_pkg::REG_ACCEL_RATE, mdsl_pkg::REG_DECEL_RATE,
            mdsl_pkg::REG_REVERSE_RATE, mdsl_pkg::REG_ZERO_HOLD_MS};
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    accel_r = acc;
    decel_r = dec;
    reverse_r = rev;
    hold_ms_r = hms;
  endtask

  task automatic run_random(input int n);
    int                 left, run, r;
    logic signed [15:0] tgt;
    left = n;
    while (left > 0) begin
      // hold one command for a run of ticks, as a controller would
      run = $urandom_range(1, 12);
      r = $urandom_range(99);
      if (r < 8) tgt = 16'sd32767;
      else if (r < 16) tgt = -16'sd32767;
      else if (r < 22) tgt = 16'sh8000;
      else if (r < 30) tgt = 16'sd0;
      else tgt = 16'($urandom);
      for (int i = 0; i < run && left > 0; i++) begin
        if ($urandom_range(99) < 3) push_item(mdsl_pkg::OP_STOP, 16'($urandom), 16'($urandom));
        else push_item(mdsl_pkg::OP_TICK, tgt, pick_dt());
        left--;
      end
    end
  endtask

  initial begin : stimulus
    stim_row_t row;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_regs(24'hFFFFFF, 24'd40000, 24'd65536, 16'd1);
    foreach (STEER_ROWS[i]) begin
      row = STEER_ROWS[i];
      push_item(row.op, row.target, row.dt, row.known, '{row.duty, row.hold_left});
    end
    await_drain();

    // rest time climbs to just short of the longest hold, a reversal waits, then passes
    quiet <= 1'b1;
    write_regs(24'hFFFFFF, mdsl_pkg::RATE_RESET, mdsl_pkg::RATE_RESET, 16'hFFFF);
    push_item(mdsl_pkg::OP_TICK, 16'sd32767, 16'hFFFF);
    push_item(mdsl_pkg::OP_STOP, 16'sd0, 16'd0);
    for (int i = 0; i < LONG_REST_TICKS; i++) push_item(mdsl_pkg::OP_TICK, 16'sd0, 16'hFFFF);
    push_item(mdsl_pkg::OP_TICK, -16'sd32767, 16'd1);
    push_item(mdsl_pkg::OP_TICK, -16'sd32767, 16'hFFFF);
    await_drain();
    quiet <= 1'b0;

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_regs(mdsl_pkg::RATE_RESET, mdsl_pkg::RATE_RESET, mdsl_pkg::RATE_RESET, 16'd0);
        1: write_regs(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
        2: write_regs(24'd0, 24'd0, 24'd0, 16'd0);
        3: write_regs(24'hFFFFFF, 24'd1, 24'd0, 16'd3);
        4: write_regs(24'($urandom_range(0, 400000)), 24'($urandom_range(0, 400000)),
                      24'($urandom_range(0, 400000)), 16'($urandom_range(0, 20)));
        5: write_regs(24'($urandom_range(1000, 200000)), 24'($urandom_range(1000, 200000)),
                      24'($urandom_range(1000, 200000)), 16'($urandom_range(0, 5)));
        6: write_regs(24'($urandom), 24'($urandom), 24'($urandom), 16'($urandom));
        default: write_regs(24'd65536, 24'd65536, 24'd0, 16'd1);
      endcase
      // output held off for a long stretch while input keeps coming
      if (ph == 5) stall_reqs <= stall_reqs + 1;
      run_random(PHASE_ITEMS);
      await_drain();
    end

    repeat (10) @(posedge clk_i);
    if (errors == 0 && duty_expq.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin : result_sink
    int hold_off;
    int seen;
    hold_off = 0;
    seen = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_reqs != seen) begin
        seen = stall_reqs;
        hold_off = HOLD_OFF_CYCLES;
      end
      if (hold_off > 0) begin
        hold_off--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= quiet || ($urandom_range(99) >= 18);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    slew_res_t          want;
    logic signed [15:0] got_duty;
    logic [25:0]        got_hold;
    got_duty = m_axis_tdata[15:0];
    got_hold = m_axis_tdata[41:16];
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (duty_expq.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending, duty %0d hold %0d", $time, got_duty,
                 got_hold);
      end else begin
        want = duty_expq.pop_front();
        if (got_duty !== want.duty) begin
          errors++;
          $display("%0t: duty expected %0d actual %0d", $time, want.duty, got_duty);
        end
        if (got_hold !== want.hold_left) begin
          errors++;
          $display("%0t: hold_left_us expected %0d actual %0d", $time, want.hold_left,
                   got_hold);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule
